// ----- hdl/s2a_pkg.sv -----
// Shared constants and scan code lookup tables for the scan code to ASCII FIFO.
// No dependencies; used by the top level.
package s2a_pkg;

  localparam int FIFO_DEPTH = 256;

  localparam logic [6:0] CODE_LSHIFT = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT = 7'h36;
  localparam logic [6:0] CODE_CTRL   = 7'h1D;
  localparam logic [6:0] CODE_CAPS   = 7'h3A;
  localparam logic [6:0] CODE_P      = 7'h19;
  localparam logic [6:0] CODE_N      = 7'h31;
  localparam logic [7:0] TABLE_LEN   = 8'd58;

  localparam logic [6:0] CHAR_CTRL_P = 7'h10;
  localparam logic [6:0] CHAR_CTRL_N = 7'h0E;
  localparam logic [6:0] CHAR_NONE   = 7'h00;

  function automatic logic [6:0] plain_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h71;
      6'd17: c = 7'h77;
      6'd18: c = 7'h65;
      6'd19: c = 7'h72;
      6'd20: c = 7'h74;
      6'd21: c = 7'h79;
      6'd22: c = 7'h75;
      6'd23: c = 7'h69;
      6'd24: c = 7'h6F;
      6'd25: c = 7'h70;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;
      6'd31: c = 7'h73;
      6'd32: c = 7'h64;
      6'd33: c = 7'h66;
      6'd34: c = 7'h67;
      6'd35: c = 7'h68;
      6'd36: c = 7'h6A;
      6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;
      6'd45: c = 7'h78;
      6'd46: c = 7'h63;
      6'd47: c = 7'h76;
      6'd48: c = 7'h62;
      6'd49: c = 7'h6E;
      6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shift_char(input logic [5:0] code);
    logic [6:0] c;
    case (code)
      6'd2:  c = 7'h21;
      6'd3:  c = 7'h40;
      6'd4:  c = 7'h23;
      6'd5:  c = 7'h24;
      6'd6:  c = 7'h25;
      6'd7:  c = 7'h5E;
      6'd8:  c = 7'h26;
      6'd9:  c = 7'h2A;
      6'd10: c = 7'h28;
      6'd11: c = 7'h29;
      6'd12: c = 7'h5F;
      6'd13: c = 7'h2B;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h51;
      6'd17: c = 7'h57;
      6'd18: c = 7'h45;
      6'd19: c = 7'h52;
      6'd20: c = 7'h54;
      6'd21: c = 7'h59;
      6'd22: c = 7'h55;
      6'd23: c = 7'h49;
      6'd24: c = 7'h4F;
      6'd25: c = 7'h50;
      6'd26: c = 7'h7B;
      6'd27: c = 7'h7D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h41;
      6'd31: c = 7'h53;
      6'd32: c = 7'h44;
      6'd33: c = 7'h46;
      6'd34: c = 7'h47;
      6'd35: c = 7'h48;
      6'd36: c = 7'h4A;
      6'd37: c = 7'h4B;
      6'd38: c = 7'h4C;
      6'd39: c = 7'h3A;
      6'd40: c = 7'h22;
      6'd41: c = 7'h7E;
      6'd43: c = 7'h7C;
      6'd44: c = 7'h5A;
      6'd45: c = 7'h58;
      6'd46: c = 7'h43;
      6'd47: c = 7'h56;
      6'd48: c = 7'h42;
      6'd49: c = 7'h4E;
      6'd50: c = 7'h4D;
      6'd51: c = 7'h3C;
      6'd52: c = 7'h3E;
      6'd53: c = 7'h3F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = CHAR_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/s2a_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module s2a_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/scancode_to_ascii_fifo_top.sv -----
// PS/2 set-1 scan code decoder with a character FIFO held in block RAM.
// Depends on s2a_pkg and s2a_ram.
//
// The block accepts one request per clock cycle when not stalled, either a scan
// code byte or a character read, and returns exactly one result per request.
// Modifier flags and the FIFO pointers live in flip-flops and are updated in the
// accept cycle; the characters live in one RAM with a single write port and a
// registered read port, so the read data of a pop arrives in the next cycle. An
// output register behind that stage lets a new request enter while a finished
// result waits. The FIFO holds at most FIFO_DEPTH-1 characters.
module scancode_to_ascii_fifo_top #(
  parameter int FIFO_DEPTH = s2a_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_scan_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_read_char,
  output logic       out_char_popped,
  output logic       out_has_input,
  output logic       out_dropped
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

  logic          shift_r, shift_nxt;
  logic          ctrl_r, ctrl_nxt;
  logic          caps_r, caps_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_pop_r, s1_has_r, s1_drop_r;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_char_r;
  logic          out_pop_r, out_has_r, out_drop_r;

  logic          accept, s1_move;
  logic          is_press, is_shift, is_ctrl, is_caps;
  logic [6:0]    code;
  logic [6:0]    dec_char;
  logic [6:0]    plain_c;
  logic          non_empty, full, is_char;
  logic          do_pop, do_push, drop;
  logic [AW-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [6:0]    ram_rdata;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  assign code     = in_scan_byte[6:0];
  assign is_press = !in_scan_byte[7];
  assign is_shift = (code == s2a_pkg::CODE_LSHIFT) || (code == s2a_pkg::CODE_RSHIFT);
  assign is_ctrl  = (code == s2a_pkg::CODE_CTRL);
  assign is_caps  = (code == s2a_pkg::CODE_CAPS);

  always_comb begin
    plain_c  = s2a_pkg::plain_char(in_scan_byte[5:0]);
    dec_char = s2a_pkg::CHAR_NONE;
    if (ctrl_r) begin
      if (code == s2a_pkg::CODE_P) begin
        dec_char = s2a_pkg::CHAR_CTRL_P;
      end else if (code == s2a_pkg::CODE_N) begin
        dec_char = s2a_pkg::CHAR_CTRL_N;
      end
    end else if (in_scan_byte < s2a_pkg::TABLE_LEN) begin
      if (shift_r) begin
        dec_char = s2a_pkg::shift_char(in_scan_byte[5:0]);
      end else if (caps_r && (plain_c inside {[7'h61:7'h7A]})) begin
        dec_char = plain_c - 7'h20;
      end else begin
        dec_char = plain_c;
      end
    end
  end

  assign wr_ptr_inc = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
  assign rd_ptr_inc = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
  assign non_empty  = (rd_ptr_r != wr_ptr_r);
  assign full       = (wr_ptr_inc == rd_ptr_r);
  assign is_char    = is_press && !is_shift && !is_ctrl && !is_caps
                      && (dec_char != s2a_pkg::CHAR_NONE);
  assign do_pop     = accept && in_action && non_empty;
  assign do_push    = accept && !in_action && is_char && !full;
  assign drop       = !in_action && is_char && full;

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    caps_nxt  = caps_r;
    if (accept && !in_action) begin
      if (!is_press) begin
        if (is_shift) begin
          shift_nxt = 1'b0;
        end else if (is_ctrl) begin
          ctrl_nxt = 1'b0;
        end
      end else if (is_shift) begin
        shift_nxt = 1'b1;
      end else if (is_ctrl) begin
        ctrl_nxt = 1'b1;
      end else if (is_caps) begin
        caps_nxt = !caps_r;
      end
    end
    rd_ptr_nxt = do_pop ? rd_ptr_inc : rd_ptr_r;
    wr_ptr_nxt = do_push ? wr_ptr_inc : wr_ptr_r;
    s1_valid_nxt = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 1'b0;
      ctrl_r      <= 1'b0;
      caps_r      <= 1'b0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      ctrl_r      <= ctrl_nxt;
      caps_r      <= caps_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop_r  <= do_pop;
      s1_has_r  <= (rd_ptr_nxt != wr_ptr_nxt);
      s1_drop_r <= drop;
    end
    if (s1_move) begin
      out_char_r <= s1_pop_r ? ram_rdata : s2a_pkg::CHAR_NONE;
      out_pop_r  <= s1_pop_r;
      out_has_r  <= s1_has_r;
      out_drop_r <= s1_drop_r;
    end
  end

  s2a_ram #(
    .WIDTH(7),
    .DEPTH(FIFO_DEPTH)
  ) u_char_ram (
    .clk    (clk),
    .wr_en  (do_push),
    .wr_addr(wr_ptr_r),
    .wr_data(dec_char),
    .rd_en  (do_pop),
    .rd_addr(rd_ptr_r),
    .rd_data(ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_read_char   = out_char_r;
  assign out_char_popped = out_pop_r;
  assign out_has_input   = out_has_r;
  assign out_dropped     = out_drop_r;

endmodule

// ----- hdl/s2a_checker.sv -----
// Port-level checker for the scan code to ASCII FIFO, bound to the top level.
// Depends on scancode_to_ascii_fifo_top.
module s2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_read_char,
  input logic       out_char_popped,
  input logic       out_has_input,
  input logic       out_dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_char)
      && $stable(out_char_popped) && $stable(out_has_input) && $stable(out_dropped))
    else $error("Result changed while stalled.");

  a_no_pop_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_popped |-> out_read_char == 7'd0)
    else $error("Character reported without a pop.");

  a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_popped |-> out_read_char != 7'd0)
    else $error("Popped character is zero.");

  a_drop_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> !out_char_popped && out_has_input)
    else $error("Drop reported with a pop or an empty FIFO.");

endmodule

bind scancode_to_ascii_fifo_top s2a_checker u_s2a_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_char  (out_read_char),
  .out_char_popped(out_char_popped),
  .out_has_input  (out_has_input),
  .out_dropped    (out_dropped)
);
